// ----- rtl/lbbt_pkg.sv -----
// Shared types, constants and command codes of the label bounding-box tracker.
// Used by every module of the block; depends on nothing.
package lbbt_pkg;

    // Sizes of the label table and of one coordinate.
    localparam int MAX_LABELS   = 255;
    localparam int COORD_BITS   = 16;
    localparam int ADDR_BITS    = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;

    // Fixed field widths of the stream and configuration ports.
    localparam int LABEL_BITS   = 8;
    localparam int CMD_BITS     = 2;
    localparam int FIELD_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Coordinates reported for a label that was not seen.
    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Input command codes.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_VOXEL = 2'd0,
        CMD_START = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_X_FIRST     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_LAST      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_FIRST     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LAST      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_Z_FIRST     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_Z_LAST      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_LABEL_COUNT = 3'd6;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

    // One table entry: minimum corner in the low half, maximum in the high half.
    typedef struct packed {
        vec3_t mx;
        vec3_t mn;
    } box_t;

    typedef struct packed {
        vec3_t                 first;
        vec3_t                 last;
        logic [LABEL_BITS-1:0] label_count;
    } cfg_t;

    // Item handed from the position walker to the box store.
    typedef struct packed {
        logic                 valid;
        logic                 is_query;
        logic                 track;
        logic [ADDR_BITS-1:0] addr;
        vec3_t                pos;
    } stage_t;

    typedef struct packed {
        logic found;
        box_t box;
    } result_t;

endpackage

// ----- rtl/lbbt_pos_walker.sv -----
// Raster position counters and label decode of the bounding-box tracker.
// Depends on lbbt_pkg; feeds lbbt_box_store with one stage item per beat.
module lbbt_pos_walker
    import lbbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  accept,
    input  cmd_t                  command,
    input  logic [LABEL_BITS-1:0] voxel_label,
    input  logic [LABEL_BITS-1:0] query_label,
    output stage_t                item
);

    vec3_t pos_reg;
    vec3_t pos_next;
    logic  done_reg;
    logic  done_next;
    logic  extent_empty;
    logic  take;
    logic  voxel_track;
    logic  query_track;

    // A label is tracked when it lies in 1 to label_count and in the table.
    function automatic logic label_ok(input logic [LABEL_BITS-1:0] lab,
                                      input logic [LABEL_BITS-1:0] cnt);
        logic ok;
        ok = (lab != '0) && (lab <= cnt)
             && ({1'b0, lab} <= (LABEL_BITS+1)'(MAX_LABELS));
        return ok;
    endfunction

    // The walk stops on an empty extent or after the last voxel.
    assign extent_empty = ($signed(cfg.first.x) > $signed(cfg.last.x))
                       || ($signed(cfg.first.y) > $signed(cfg.last.y))
                       || ($signed(cfg.first.z) > $signed(cfg.last.z));
    assign take         = !extent_empty && !done_reg;
    assign voxel_track  = take && label_ok(voxel_label, cfg.label_count);
    assign query_track  = label_ok(query_label, cfg.label_count);

    // Stage item for the box store, built from the position before the advance.
    always_comb
    begin
        item.valid    = accept && (((command == CMD_VOXEL) && voxel_track)
                                   || (command == CMD_QUERY));
        item.is_query = (command == CMD_QUERY);
        item.track    = (command == CMD_QUERY) ? query_track : voxel_track;
        item.addr     = (command == CMD_QUERY) ? ADDR_BITS'(query_label - 1'b1)
                                               : ADDR_BITS'(voxel_label - 1'b1);
        item.pos      = pos_reg;
    end

    // Next position: x fastest, then y, then z; the last plane ends the walk.
    always_comb
    begin
        pos_next  = pos_reg;
        done_next = done_reg;
        if (accept)
        begin
            case (command)
                CMD_START:
                begin
                    pos_next  = cfg.first;
                    done_next = 1'b0;
                end
                CMD_VOXEL:
                begin
                    if (take)
                    begin
                        if ($signed(pos_reg.x) < $signed(cfg.last.x))
                        begin
                            pos_next.x = pos_reg.x + 1'b1;
                        end
                        else
                        begin
                            pos_next.x = cfg.first.x;
                            if ($signed(pos_reg.y) < $signed(cfg.last.y))
                            begin
                                pos_next.y = pos_reg.y + 1'b1;
                            end
                            else
                            begin
                                pos_next.y = cfg.first.y;
                                if ($signed(pos_reg.z) < $signed(cfg.last.z))
                                begin
                                    pos_next.z = pos_reg.z + 1'b1;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    pos_next  = pos_reg;
                    done_next = done_reg;
                end
            endcase
        end
    end

    // Counter registers; reset matches the reset value of the first indices.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

endmodule

// ----- rtl/lbbt_box_store.sv -----
// Box table memory with read-modify-write update, seen bits and forwarding.
// Depends on lbbt_pkg; takes stage items from lbbt_pos_walker.
module lbbt_box_store
    import lbbt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage_t  item,
    input  logic    clear,
    input  logic    out_block,
    output logic    stall,
    output logic    res_valid,
    output result_t result
);

    box_t                 box_mem [MAX_LABELS];
    box_t                 rdata_reg;
    stage_t               s1_reg;
    logic [MAX_LABELS-1:0] seen_reg;
    logic                 fwd_valid_reg;
    logic [ADDR_BITS-1:0] fwd_addr_reg;
    box_t                 fwd_data_reg;
    logic [ADDR_BITS-1:0] rd_addr;
    box_t                 cur_box;
    box_t                 new_box;
    logic                 seen_k;
    logic                 wr_en;

    // A query holds in the second stage while the output register is full and not taken.
    assign res_valid = s1_reg.valid && s1_reg.is_query;
    assign stall     = res_valid && out_block;
    assign wr_en     = s1_reg.valid && !s1_reg.is_query;

    // A stalled query keeps reading its own entry.
    assign rd_addr = stall ? s1_reg.addr : item.addr;

    // The entry written at the previous edge is not yet in the read data.
    assign cur_box = (fwd_valid_reg && (fwd_addr_reg == s1_reg.addr)) ? fwd_data_reg
                                                                     : rdata_reg;
    assign seen_k  = (32'(s1_reg.addr) < MAX_LABELS) ? seen_reg[s1_reg.addr] : 1'b0;

    // Widen the box by the current position, or start it on first sight.
    always_comb
    begin
        if (!seen_k)
        begin
            new_box.mn = s1_reg.pos;
            new_box.mx = s1_reg.pos;
        end
        else
        begin
            new_box.mn.x = ($signed(s1_reg.pos.x) < $signed(cur_box.mn.x)) ? s1_reg.pos.x
                                                                          : cur_box.mn.x;
            new_box.mn.y = ($signed(s1_reg.pos.y) < $signed(cur_box.mn.y)) ? s1_reg.pos.y
                                                                          : cur_box.mn.y;
            new_box.mn.z = ($signed(s1_reg.pos.z) < $signed(cur_box.mn.z)) ? s1_reg.pos.z
                                                                          : cur_box.mn.z;
            new_box.mx.x = ($signed(s1_reg.pos.x) > $signed(cur_box.mx.x)) ? s1_reg.pos.x
                                                                          : cur_box.mx.x;
            new_box.mx.y = ($signed(s1_reg.pos.y) > $signed(cur_box.mx.y)) ? s1_reg.pos.y
                                                                          : cur_box.mx.y;
            new_box.mx.z = ($signed(s1_reg.pos.z) > $signed(cur_box.mx.z)) ? s1_reg.pos.z
                                                                          : cur_box.mx.z;
        end
    end

    // Query answer; an unseen or untracked label gives the empty box.
    always_comb
    begin
        result.found = s1_reg.track && seen_k;
        if (result.found)
        begin
            result.box = cur_box;
        end
        else
        begin
            result.box.mn = '{z: COORD_MAX, y: COORD_MAX, x: COORD_MAX};
            result.box.mx = '{z: COORD_MIN, y: COORD_MIN, x: COORD_MIN};
        end
    end

    // Box memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            box_mem[s1_reg.addr] <= new_box;
        end
        rdata_reg <= box_mem[rd_addr];
    end

    // Forwarding copy of the last write.
    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s1_reg.addr;
        fwd_data_reg <= new_box;
    end

    // Second-stage item, forwarding flag and seen bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            fwd_valid_reg <= 1'b0;
            seen_reg      <= '0;
        end
        else
        begin
            if (!stall)
            begin
                s1_reg <= item;
            end
            fwd_valid_reg <= wr_en;
            if (clear)
            begin
                seen_reg <= '0;
            end
            else if (wr_en)
            begin
                seen_reg[s1_reg.addr] <= 1'b1;
            end
        end
    end

    // A stalled item is always a query, so nothing is written meanwhile.
    a_no_write_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !wr_en)
        else $error("box write while the second stage is stalled");

    // Forwarded data always comes from a write at the previous edge.
    a_fwd_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> $past(wr_en))
        else $error("forwarding flag without a preceding write");

    // A found result needs a tracked label.
    a_found_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && result.found) |-> s1_reg.track)
        else $error("found reported for an untracked label");

    // A stalled query keeps the same entry address.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (s1_reg.addr == $past(s1_reg.addr)) && s1_reg.is_query)
        else $error("stalled query changed its entry");

endmodule

// ----- rtl/label_bounding_box_tracker.sv -----
// Top level of the label bounding-box tracker: configuration registers,
// output register and the walker and box store. Depends on lbbt_pkg.
//
// The block takes one beat per clock unless stalled: voxel labels in raster
// order (x fastest), start-frame and query commands. Every voxel beat walks the
// x, y and z counters over the configured extent and, for a tracked label,
// updates that label's box in a table memory with a read in the accept cycle
// and a write in the next cycle; back-to-back voxels of one label are served by
// forwarding the last write, so the sustained rate is one beat per cycle. A
// query result goes from the second stage into the output register; the input
// stalls only while a query result waits in the second stage behind a full
// output register that is not taken. Seen marks are flip-flops, so start frame
// clears them at once and no clearing pass follows reset. The user must write
// configuration only while the block is idle; the block does not enforce it.
module label_bounding_box_tracker
    import lbbt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Input stream.
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [15:0]             s_tdata,   // voxel_label[7:0], query_label[15:8]
    input  logic [CMD_BITS-1:0]     s_tuser,   // command[1:0]
    // Result stream.
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [6*FIELD_BITS-1:0] m_tdata,   // x_min, x_max, y_min, y_max, z_min, z_max
    output logic                    m_tuser,   // found
    // Configuration writes.
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]   cfg_data
);

    cfg_t    cfg_reg;
    logic    accept;
    cmd_t    command;
    stage_t  item;
    logic    stall;
    logic    res_valid;
    result_t result;
    logic    out_block;
    logic    out_valid_reg;
    result_t out_reg;
    coord_t  cfg_coord;

    assign cfg_ready = 1'b1;
    assign cfg_coord = COORD_BITS'(cfg_data);

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first       <= '{z: '0, y: '0, x: '0};
            cfg_reg.last        <= '{z: COORD_BITS'(255), y: COORD_BITS'(255),
                                     x: COORD_BITS'(255)};
            cfg_reg.label_count <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_FIRST:     cfg_reg.first.x     <= cfg_coord;
                REG_X_LAST:      cfg_reg.last.x      <= cfg_coord;
                REG_Y_FIRST:     cfg_reg.first.y     <= cfg_coord;
                REG_Y_LAST:      cfg_reg.last.y      <= cfg_coord;
                REG_Z_FIRST:     cfg_reg.first.z     <= cfg_coord;
                REG_Z_LAST:      cfg_reg.last.z      <= cfg_coord;
                REG_LABEL_COUNT: cfg_reg.label_count <= cfg_data[LABEL_BITS-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Input handshake.
    assign s_tready = !stall;
    assign accept   = s_tvalid && s_tready;
    assign command  = cmd_t'(s_tuser);

    lbbt_pos_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .command     (command),
        .voxel_label (s_tdata[LABEL_BITS-1:0]),
        .query_label (s_tdata[2*LABEL_BITS-1:LABEL_BITS]),
        .item        (item)
    );

    lbbt_box_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .clear     (accept && (command == CMD_START)),
        .out_block (out_block),
        .stall     (stall),
        .res_valid (res_valid),
        .result    (result)
    );

    // Output register: loads a query result whenever it is empty or being taken.
    assign out_block = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && !out_block)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && !out_block)
        begin
            out_reg <= result;
        end
    end

    // Result packing, lowest field first.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.found;
    assign m_tdata  = {FIELD_BITS'($unsigned(out_reg.box.mx.z)),
                       FIELD_BITS'($unsigned(out_reg.box.mn.z)),
                       FIELD_BITS'($unsigned(out_reg.box.mx.y)),
                       FIELD_BITS'($unsigned(out_reg.box.mn.y)),
                       FIELD_BITS'($unsigned(out_reg.box.mx.x)),
                       FIELD_BITS'($unsigned(out_reg.box.mn.x))};

endmodule
